// ----- hdl/differential_drive_slew_ramp_macros.svh -----
// assertion helpers used by the checker file
`ifndef DIFFERENTIAL_DRIVE_SLEW_RAMP_MACROS_SVH
`define DIFFERENTIAL_DRIVE_SLEW_RAMP_MACROS_SVH

// condition must never hold while out of reset
`define DDSR_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
		else $error("ddsr assertion failed");

// same-cycle implication
`define DDSR_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("ddsr assertion failed");

// next-cycle implication
`define DDSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("ddsr assertion failed");

`endif

// ----- hdl/ddsr_pkg.sv -----
`default_nettype none
package ddsr_pkg;

	localparam int DUTY_W = 8;
	localparam int CMD_W = DUTY_W + 1;
	localparam int INTERVAL_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [INTERVAL_W-1:0] TICKS_DUE = '1;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT_MAX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL = 2'd3;

	localparam logic [DUTY_W-1:0] LEFT_MAX_RESET = 8'd255;
	localparam logic [DUTY_W-1:0] RIGHT_MAX_RESET = 8'd255;
	localparam logic [DUTY_W-1:0] RAMP_STEP_RESET = 8'd5;
	localparam logic [INTERVAL_W-1:0] RAMP_INTERVAL_RESET = 16'd10;

	typedef enum logic [2:0] {
		MOTION_STOP = 3'd0,
		MOTION_FORWARD = 3'd1,
		MOTION_BACKWARD = 3'd2,
		MOTION_TURN_LEFT = 3'd3,
		MOTION_TURN_RIGHT = 3'd4
	} motion_t;

	typedef enum logic [1:0] {
		DIR_STOP = 2'b00,
		DIR_FWD = 2'b01,
		DIR_REV = 2'b11
	} dir_t;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_MOTION = 1'b1;

endpackage
`default_nettype wire

// ----- hdl/differential_drive_slew_ramp.sv -----
// Two-side H-bridge drive with slew-rate ramping. Each request is a 1 ms tick or a
// motion command; every request returns one result with both sides' direction pins,
// PWM duty and a changed flag. The block takes one request per clock unless stalled: a
// request is held in the input register, the ramp step and drive update are done in a
// single pass from there into the result register, and back-to-back requests stream at
// full rate. Downstream stall holds the result register and then the input register.
// Configuration writes take effect at once and make the next tick due; write them only
// while no request is in flight.
`default_nettype none
module differential_drive_slew_ramp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_stall,
	input  wire logic                            req_type,
	input  wire logic [2:0]                      motion,
	output      logic                            out_valid,
	input  wire logic                            out_stall,
	output      logic                            left_forward,
	output      logic                            left_reverse,
	output      logic [ddsr_pkg::DUTY_W-1:0]     left_duty,
	output      logic                            right_forward,
	output      logic                            right_reverse,
	output      logic [ddsr_pkg::DUTY_W-1:0]     right_duty,
	output      logic                            changed,
	input  wire logic                            cfg_we,
	input  wire logic [ddsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ddsr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ddsr_pkg::*;

	logic [DUTY_W-1:0] left_max_q, right_max_q, ramp_step_q;
	logic [INTERVAL_W-1:0] ramp_interval_q;

	logic signed [CMD_W-1:0] left_cmd_q, right_cmd_q;
	dir_t left_dir_q, right_dir_q;
	logic [INTERVAL_W-1:0] ticks_q;

	logic valid_s1, req_s1;
	logic [2:0] motion_s1;

	logic out_valid_q, changed_q;
	logic left_fwd_q, left_rev_q, right_fwd_q, right_rev_q;
	logic [DUTY_W-1:0] left_duty_q, right_duty_q;

	logic out_free, fire;
	dir_t left_dir_n, right_dir_n;
	logic [INTERVAL_W-1:0] interval_eff, count_n;
	logic [DUTY_W-1:0] step_eff;
	logic due;
	logic signed [CMD_W-1:0] left_tgt, right_tgt, left_step, right_step;
	logic signed [CMD_W-1:0] left_cmd_n, right_cmd_n;
	logic changed_n;

	function automatic logic signed [CMD_W-1:0] target(input dir_t d, input logic [DUTY_W-1:0] mx);
		logic signed [CMD_W-1:0] m;
		m = signed'({1'b0, mx});
		case (d)
			DIR_FWD: target = m;
			DIR_REV: target = -m;
			default: target = '0;
		endcase
	endfunction

	function automatic logic signed [CMD_W-1:0] move_toward(
		input logic signed [CMD_W-1:0] cur,
		input logic signed [CMD_W-1:0] tgt,
		input logic [DUTY_W-1:0] step
	);
		logic signed [CMD_W:0] c, t, s, up, dn, r;
		c = (CMD_W+1)'(cur);
		t = (CMD_W+1)'(tgt);
		s = signed'({2'b00, step});
		up = c + s;
		dn = c - s;
		if (c == t) begin
			r = c;
		end else if (t == 0 || (t > 0 && c < 0) || (t < 0 && c > 0)) begin
			if (c > 0) begin
				r = (dn < 0) ? '0 : dn;
			end else begin
				r = (up > 0) ? '0 : up;
			end
		end else if (t > 0) begin
			r = (up > t) ? t : up;
		end else begin
			r = (dn < t) ? t : dn;
		end
		move_toward = r[CMD_W-1:0];
	endfunction

	function automatic logic [DUTY_W-1:0] magnitude(input logic signed [CMD_W-1:0] cmd);
		logic signed [CMD_W-1:0] a;
		a = (cmd < 0) ? -cmd : cmd;
		magnitude = a[DUTY_W-1:0];
	endfunction

	assign out_free = !out_valid_q || !out_stall;
	assign fire = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_comb begin
		case (motion_s1)
			MOTION_FORWARD: begin
				left_dir_n = DIR_FWD;
				right_dir_n = DIR_FWD;
			end
			MOTION_BACKWARD: begin
				left_dir_n = DIR_REV;
				right_dir_n = DIR_REV;
			end
			MOTION_TURN_LEFT: begin
				left_dir_n = DIR_REV;
				right_dir_n = DIR_FWD;
			end
			MOTION_TURN_RIGHT: begin
				left_dir_n = DIR_FWD;
				right_dir_n = DIR_REV;
			end
			default: begin
				left_dir_n = DIR_STOP;
				right_dir_n = DIR_STOP;
			end
		endcase
	end

	assign interval_eff = (ramp_interval_q == '0) ? INTERVAL_W'(1) : ramp_interval_q;
	assign step_eff = (ramp_step_q == '0) ? DUTY_W'(1) : ramp_step_q;
	assign count_n = (ticks_q == TICKS_DUE) ? TICKS_DUE : ticks_q + INTERVAL_W'(1);
	assign due = count_n >= interval_eff;

	assign left_tgt = target(left_dir_q, left_max_q);
	assign right_tgt = target(right_dir_q, right_max_q);
	assign left_step = move_toward(left_cmd_q, left_tgt, step_eff);
	assign right_step = move_toward(right_cmd_q, right_tgt, step_eff);

	always_comb begin
		left_cmd_n = left_cmd_q;
		right_cmd_n = right_cmd_q;
		changed_n = 1'b0;
		if (req_s1 == REQ_TICK && due) begin
			left_cmd_n = left_step;
			right_cmd_n = right_step;
			changed_n = (left_step != left_cmd_q) || (right_step != right_cmd_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= req_type;
			motion_s1 <= motion;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_max_q <= LEFT_MAX_RESET;
			right_max_q <= RIGHT_MAX_RESET;
			ramp_step_q <= RAMP_STEP_RESET;
			ramp_interval_q <= RAMP_INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_MAX: left_max_q <= cfg_data[DUTY_W-1:0];
				REG_RIGHT_MAX: right_max_q <= cfg_data[DUTY_W-1:0];
				REG_RAMP_STEP: ramp_step_q <= cfg_data[DUTY_W-1:0];
				REG_RAMP_INTERVAL: ramp_interval_q <= cfg_data[INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_cmd_q <= '0;
			right_cmd_q <= '0;
			left_dir_q <= DIR_STOP;
			right_dir_q <= DIR_STOP;
			ticks_q <= '0;
		end else if (cfg_we) begin
			ticks_q <= TICKS_DUE;
		end else if (fire) begin
			left_cmd_q <= left_cmd_n;
			right_cmd_q <= right_cmd_n;
			if (req_s1 == REQ_MOTION) begin
				left_dir_q <= left_dir_n;
				right_dir_q <= right_dir_n;
				ticks_q <= TICKS_DUE;
			end else if (due) begin
				ticks_q <= '0;
			end else begin
				ticks_q <= count_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			left_fwd_q <= left_cmd_n > 0;
			left_rev_q <= left_cmd_n < 0;
			left_duty_q <= magnitude(left_cmd_n);
			right_fwd_q <= right_cmd_n > 0;
			right_rev_q <= right_cmd_n < 0;
			right_duty_q <= magnitude(right_cmd_n);
			changed_q <= changed_n;
		end
	end

	assign out_valid = out_valid_q;
	assign left_forward = left_fwd_q;
	assign left_reverse = left_rev_q;
	assign left_duty = left_duty_q;
	assign right_forward = right_fwd_q;
	assign right_reverse = right_rev_q;
	assign right_duty = right_duty_q;
	assign changed = changed_q;

endmodule
`default_nettype wire

// ----- hdl/ddsr_checker.sv -----
`default_nettype none
`include "differential_drive_slew_ramp_macros.svh"
module ddsr_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic                            left_forward,
	input wire logic                            left_reverse,
	input wire logic [ddsr_pkg::DUTY_W-1:0]     left_duty,
	input wire logic                            right_forward,
	input wire logic                            right_reverse,
	input wire logic [ddsr_pkg::DUTY_W-1:0]     right_duty,
	input wire logic                            changed
);
	import ddsr_pkg::*;

	// a bridge side never drives both pins
	`DDSR_ASSERT_NEVER(a_left_pins, clk, arst_n, out_valid && left_forward && left_reverse)
	`DDSR_ASSERT_NEVER(a_right_pins, clk, arst_n, out_valid && right_forward && right_reverse)
	// nonzero duty only with a direction, and a direction only with duty
	`DDSR_ASSERT_IMPLY(a_left_duty, clk, arst_n, out_valid,
		(left_duty != '0) == (left_forward || left_reverse))
	`DDSR_ASSERT_IMPLY(a_right_duty, clk, arst_n, out_valid,
		(right_duty != '0) == (right_forward || right_reverse))
	// a stalled result holds
	`DDSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(left_duty) && $stable(right_duty) && $stable(changed))

endmodule

bind differential_drive_slew_ramp ddsr_checker u_ddsr_checker (.*);
`default_nettype wire
